// ----- rtl/deq_pkg.sv -----
// Package for the double-ended queue block: sizes, request codes,
// command and result types, index helpers. No dependencies.
package deq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int VAL_W       = 32;
    localparam int REQ_W       = 3;
    localparam int FQ_DEPTH    = 2;
    localparam int FQ_PW       = $clog2(FQ_DEPTH);
    localparam int FQ_CW       = $clog2(FQ_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT_GT   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CONTAINS   = 3'd5;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [OCC_W-1:0]        occ_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_COUNT_GT,
        OP_CONTAINS,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_WALK,
        ST_QDONE
    } state_t;

    typedef struct packed {
        op_t    op;
        value_t value;
    } cmd_t;

    typedef struct packed {
        value_t popped_value;
        logic   empty_error;
        logic   full_error;
        occ_t   occupancy;
        occ_t   greater_count;
        logic   key_found;
    } result_t;

    function automatic idx_t idx_next(input idx_t i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

    function automatic occ_t to_occ(input cnt_t c);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = (CNT_W + OCC_W)'(c);
        return wide[OCC_W-1:0];
    endfunction

endpackage

// ----- rtl/deq_if.sv -----
// Request and result channel interfaces (valid/ready).
// Depends on deq_pkg.
interface deq_req_if;
    import deq_pkg::*;
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    value_t             item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface deq_res_if;
    import deq_pkg::*;
    logic   valid;
    logic   ready;
    value_t popped_value;
    logic   empty_error;
    logic   full_error;
    occ_t   occupancy;
    occ_t   greater_count;
    logic   key_found;

    modport source (output valid, output popped_value, output empty_error,
                    output full_error, output occupancy, output greater_count,
                    output key_found, input ready);
    modport sink   (input valid, input popped_value, input empty_error,
                    input full_error, input occupancy, input greater_count,
                    input key_found, output ready);
endinterface

// ----- rtl/deq_front.sv -----
// Front end: accepts requests, decodes them into commands and holds them
// in a short command queue. Depends on deq_pkg and deq_if.
module deq_front (
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output deq_pkg::cmd_t cmd
);
    import deq_pkg::*;

    cmd_t               fifo_reg [FQ_DEPTH];
    logic [FQ_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FQ_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0]   fill_reg, fill_next;
    cmd_t               cmd_in;
    logic               push;
    logic               pop;

    always_comb
    begin
        cmd_in.value = req.item_value;
        case (req.req_type)
            REQ_PUSH_FRONT: cmd_in.op = OP_PUSH_FRONT;
            REQ_PUSH_BACK:  cmd_in.op = OP_PUSH_BACK;
            REQ_POP_FRONT:  cmd_in.op = OP_POP_FRONT;
            REQ_POP_BACK:   cmd_in.op = OP_POP_BACK;
            REQ_COUNT_GT:   cmd_in.op = OP_COUNT_GT;
            REQ_CONTAINS:   cmd_in.op = OP_CONTAINS;
            default:        cmd_in.op = OP_NONE;
        endcase
    end

    assign req.ready = (fill_reg != FQ_CW'(FQ_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_PW'(FQ_DEPTH - 1)) ? '0 : FQ_PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_PW'(FQ_DEPTH - 1)) ? '0 : FQ_PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            fill_next = FQ_CW'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = FQ_CW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- rtl/deq_back.sv -----
// Back end: ring store, head/tail/count, command sequencer and result
// register. Depends on deq_pkg and deq_if.
module deq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  deq_pkg::cmd_t cmd,
    deq_res_if.source     res
);
    import deq_pkg::*;

    value_t   mem [QUEUE_DEPTH];
    value_t   rd_data_reg;
    logic     wr_en, rd_en;
    idx_t     wr_addr, rd_addr;

    state_t   state_reg, state_next;
    idx_t     head_reg, head_next;
    idx_t     tail_reg, tail_next;
    cnt_t     count_reg, count_next;
    idx_t     pos_reg, pos_next;
    cnt_t     left_reg, left_next;
    logic     hit_reg, hit_next;
    cnt_t     greater_reg, greater_next;
    logic     found_reg, found_next;
    op_t      op_reg, op_next;
    value_t   key_reg, key_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;
    logic     out_free;
    logic     full;
    logic     empty;

    assign out_free = !out_valid_reg || res.ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        hit_next       = hit_reg;
        greater_next   = greater_reg;
        found_next     = found_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        rd_en          = 1'b0;
        rd_addr        = pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    op_next   = cmd.op;
                    key_next  = cmd.value;
                    out_next  = '0;
                    out_next.occupancy = to_occ(count_reg);
                    case (cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_next.full_error = 1'b1;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    wr_addr   = idx_prev(head_reg);
                                    head_next = idx_prev(head_reg);
                                end
                                else
                                begin
                                    wr_addr   = tail_reg;
                                    tail_next = idx_next(tail_reg);
                                end
                                count_next = cnt_t'(count_reg + 1'b1);
                                out_next.occupancy = to_occ(cnt_t'(count_reg + 1'b1));
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_valid_next       = 1'b1;
                                out_next.empty_error = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                if (cmd.op == OP_POP_FRONT)
                                begin
                                    rd_addr   = head_reg;
                                    head_next = idx_next(head_reg);
                                end
                                else
                                begin
                                    rd_addr   = idx_prev(tail_reg);
                                    tail_next = idx_prev(tail_reg);
                                end
                                count_next = cnt_t'(count_reg - 1'b1);
                                state_next = ST_POP;
                            end
                        end
                        OP_COUNT_GT, OP_CONTAINS:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                pos_next     = head_reg;
                                left_next    = count_reg;
                                hit_next     = 1'b0;
                                greater_next = '0;
                                found_next   = 1'b0;
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.popped_value = rd_data_reg;
                    out_next.occupancy    = to_occ(count_reg);
                    state_next            = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                hit_next = (left_reg != '0);
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = pos_reg;
                    pos_next  = idx_next(pos_reg);
                    left_next = cnt_t'(left_reg - 1'b1);
                end
                if (hit_reg)
                begin
                    if (rd_data_reg > key_reg)
                    begin
                        greater_next = cnt_t'(greater_reg + 1'b1);
                    end
                    if (rd_data_reg == key_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (left_reg == '0)
                begin
                    state_next = ST_QDONE;
                end
            end

            ST_QDONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next           = '0;
                    out_next.occupancy = to_occ(count_reg);
                    if (op_reg == OP_COUNT_GT)
                    begin
                        out_next.greater_count = to_occ(greater_reg);
                    end
                    else
                    begin
                        out_next.key_found = found_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        left_reg    <= left_next;
        greater_reg <= greater_next;
        found_reg   <= found_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.popped_value  = out_reg.popped_value;
    assign res.empty_error   = out_reg.empty_error;
    assign res.full_error    = out_reg.full_error;
    assign res.occupancy     = out_reg.occupancy;
    assign res.greater_count = out_reg.greater_count;
    assign res.key_found     = out_reg.key_found;

endmodule

// ----- rtl/double_ended_queue_with_queries.sv -----
// Top level of the double-ended queue with count and contains queries.
// Depends on deq_pkg, deq_if, deq_front, deq_back.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | req_type, item_value
//   res     | out | valid/ready  | popped_value, empty_error, full_error,
//           |     |              | occupancy, greater_count, key_found
//
// Push, unknown code, pop or query on empty: result from the idle state.
// Pop: registered ring-store read, then the result. Query: one stored entry
// read per cycle through the single ring-store read port, then the result.
// A two-entry command queue registers requests and takes them while the
// back end works. Reset empties the queue; no clearing pass.
// A stalled result holds the back end; the front keeps filling its queue.
module double_ended_queue_with_queries (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_res_if.source res
);
    import deq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    deq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res       (res)
    );

endmodule

// ----- verif/deq_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the double-ended queue: keeps a shadow copy of the ring,
// predicts the result of each accepted request and compares it with the
// result channel. Depends on deq_pkg and deq_if.
module deq_result_checker (
    input  logic clk,
    input  logic rst_n,
    deq_req_if   req_bus,
    deq_res_if   res_bus,
    output int   mismatch_count,
    output int   outstanding
);
    import deq_pkg::*;

    value_t  shadow_store [QUEUE_DEPTH];
    int      front_pos;
    int      back_pos;
    int      held;
    result_t awaited_results [$];

    function automatic result_t apply_request(input logic [REQ_W-1:0] kind, input value_t v);
        result_t r;
        int      pos;
        int      k;
        r = '0;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (held >= QUEUE_DEPTH)
                    r.full_error = 1'b1;
                else if (kind == REQ_PUSH_FRONT)
                begin
                    front_pos = (front_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    shadow_store[front_pos] = v;
                    held++;
                end
                else
                begin
                    shadow_store[back_pos] = v;
                    back_pos = (back_pos + 1) % QUEUE_DEPTH;
                    held++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (held == 0)
                    r.empty_error = 1'b1;
                else if (kind == REQ_POP_FRONT)
                begin
                    r.popped_value = shadow_store[front_pos];
                    front_pos = (front_pos + 1) % QUEUE_DEPTH;
                    held--;
                end
                else
                begin
                    back_pos = (back_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    r.popped_value = shadow_store[back_pos];
                    held--;
                end
            end
            REQ_COUNT_GT, REQ_CONTAINS:
            begin
                pos = front_pos;
                for (k = 0; k < held; k++)
                begin
                    if (kind == REQ_COUNT_GT && shadow_store[pos] > v)
                        r.greater_count++;
                    if (kind == REQ_CONTAINS && shadow_store[pos] == v)
                        r.key_found = 1'b1;
                    pos = (pos + 1) % QUEUE_DEPTH;
                end
            end
            default:
            begin
                // spare codes: no change
            end
        endcase
        r.occupancy = occ_t'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            front_pos = 0;
            back_pos = 0;
            held = 0;
            awaited_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                awaited_results.push_back(apply_request(req_bus.req_type, req_bus.item_value));
            if (res_bus.valid && res_bus.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t deq: result with no request pending: pop=%0d occ=%0d",
                                 $realtime, res_bus.popped_value, res_bus.occupancy);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.popped_value !== res_bus.popped_value
                        || want.empty_error !== res_bus.empty_error
                        || want.full_error !== res_bus.full_error
                        || want.occupancy !== res_bus.occupancy
                        || want.greater_count !== res_bus.greater_count
                        || want.key_found !== res_bus.key_found)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display({"%0t deq mismatch: expected pop=%0d empty=%0b ",
                                      "full=%0b occ=%0d gt=%0d found=%0b"},
                                     $realtime, want.popped_value, want.empty_error,
                                     want.full_error, want.occupancy, want.greater_count,
                                     want.key_found);
                            $display({"%0t deq mismatch:   actual pop=%0d empty=%0b ",
                                      "full=%0b occ=%0d gt=%0d found=%0b"},
                                     $realtime, res_bus.popped_value, res_bus.empty_error,
                                     res_bus.full_error, res_bus.occupancy,
                                     res_bus.greater_count, res_bus.key_found);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top of the double-ended queue testbench: clock, reset, request stimulus and
// result back-pressure. Depends on deq_pkg, deq_if, the block and deq_result_checker.
module testbench;
    import deq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
    localparam int RANDOM_REQUESTS  = 400;
    localparam int LONG_HOLD_AT     = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;

    typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   sender_steady;
    bit   receiver_steady;
    int   mismatch_count;
    int   outstanding;

    deq_req_if req_ch ();
    deq_res_if res_ch ();

    double_ended_queue_with_queries uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    deq_result_checker results_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_bus        (req_ch),
        .res_bus        (res_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #10 clk = ~clk;

    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3, 4: v = $signed($urandom_range(0, 16)) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind(input lean_t lean);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        push_pct = (lean == LEAN_FILL) ? 60 : (lean == LEAN_DRAIN) ? 20 : 40;
        pop_pct  = (lean == LEAN_FILL) ? 20 : (lean == LEAN_DRAIN) ? 60 : 35;
        if (roll < 2)
            return $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        if (roll < 2 + push_pct)
            return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        if (roll < 2 + push_pct + pop_pct)
            return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        return $urandom_range(0, 1) ? REQ_COUNT_GT : REQ_CONTAINS;
    endfunction

    // returns at the edge where the request is taken
    task automatic send_request(input logic [REQ_W-1:0] kind, input value_t v);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.item_value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    initial
    begin
        int               counted;
        int               i;
        lean_t            lean;
        logic [REQ_W-1:0] kind;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PUSH_FRONT;
        req_ch.item_value = '0;
        sender_steady = 1'b0;
        lean = LEAN_MIXED;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue
        send_request(REQ_POP_FRONT, 32'd7);
        send_request(REQ_POP_BACK, 32'd7);
        send_request(REQ_COUNT_GT, 32'h8000_0000);
        send_request(REQ_CONTAINS, 32'd0);
        send_request(REQ_SPARE_A, 32'hFFFF_FFFF);
        // extremes of the value range
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_BACK, 32'h8000_0000);
        send_request(REQ_PUSH_FRONT, 32'd0);
        send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(REQ_COUNT_GT, 32'hFFFF_FFFF);
        send_request(REQ_COUNT_GT, 32'h7FFF_FFFF);
        send_request(REQ_CONTAINS, 32'h8000_0000);
        send_request(REQ_SPARE_B, 32'h5555_AAAA);
        // fill to the top, then push onto a full queue
        for (i = 0; i < QUEUE_DEPTH - 4; i++)
            send_request((i % 2 == 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
        send_request(REQ_PUSH_FRONT, 32'd1);
        send_request(REQ_PUSH_BACK, 32'd2);
        send_request(REQ_COUNT_GT, 32'h8000_0000);

        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (counted % 48 == 0)
            begin
                lean = lean_t'($urandom_range(0, 2));
                sender_steady = ($urandom_range(0, 3) == 0);
            end
            kind = pick_kind(lean);
            send_request(kind, pick_value());
            if (kind <= REQ_CONTAINS)
                counted++;
        end
        req_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int hold;
        int taken;
        res_ch.ready = 1'b0;
        receiver_steady = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                receiver_steady = ($urandom_range(0, 3) == 0);
            hold = receiver_steady ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            taken++;
            // long back-pressure so the request side backs up
            if (taken == LONG_HOLD_AT)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
